>>> rtl/pfgw_pkg.sv
// Shared types, size defaults and refresh stream constants for the glyph writer.
`default_nettype none

package pfgw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int GLYPH_SPAN_DEF    = 9;

    // refresh stream: address-window command bytes, then one prefix per page
    localparam int          CMD_COUNT     = 7;
    localparam logic [2:0]  CMD_POS_FIRST = 3'd0;
    localparam logic [2:0]  CMD_POS_COL   = 3'd1;
    localparam logic [2:0]  CMD_POS_COLE  = 3'd3;
    localparam logic [2:0]  CMD_POS_PAGE  = 3'd4;
    localparam logic [2:0]  CMD_POS_PAGEE = 3'd6;
    localparam logic [2:0]  CMD_POS_LAST  = 3'(CMD_COUNT - 1);

    localparam logic [7:0]  CMD_LEAD      = 8'h00;
    localparam logic [7:0]  CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0]  CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0]  PAGE_PREFIX   = 8'h40;

    typedef enum logic [1:0] {
        REQ_PIXEL   = 2'd0,
        REQ_GLYPH   = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] f_cmd_byte(
        input logic [2:0] pos,
        input logic [7:0] last_col,
        input logic [7:0] last_page
    );
        logic [7:0] b;
        case (pos)
            CMD_POS_COL:   b = CMD_COL_ADDR;
            CMD_POS_COLE:  b = last_col;
            CMD_POS_PAGE:  b = CMD_PAGE_ADDR;
            CMD_POS_PAGEE: b = last_page;
            default:       b = CMD_LEAD;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfgw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pfgw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/page_framebuffer_glyph_writer.sv
// Top level: page-mode monochrome framebuffer with glyph-row writer and refresh stream.
// Put pixel: one read in RUN, one write-back in DRAIN, then back to IDLE for the next accept.
// Glyph row: GLYPH_SPAN columns read in RUN, each write-back overlapping the next column's read.
// Refresh byte: accept in IDLE, then EMIT loads the result register and returns to IDLE once
//   the output register is free, held off while a byte waits there.
// Reset: zero all PAGES*SCREEN_WIDTH bytes (o_in_ready low); stream restarts.
`default_nettype none

module page_framebuffer_glyph_writer #(
    parameter int SCREEN_WIDTH  = pfgw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pfgw_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_SPAN    = pfgw_pkg::GLYPH_SPAN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_req_type,
    input  wire logic signed [9:0] i_pos_x,
    input  wire logic signed [9:0] i_pos_y,
    input  wire logic              i_color,
    input  wire logic [7:0]        i_row_bits,
    // refresh byte channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_transfer_start,
    output logic                   o_frame_last
);

    import pfgw_pkg::*;

    localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH  = PAGES * SCREEN_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int CP_W   = $clog2(SCREEN_WIDTH + 1);
    localparam int CNT_W  = $clog2(GLYPH_SPAN + 1);

    localparam logic [ADDR_W-1:0] WIDTH_A    = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(PAGES - 1);
    localparam logic [CP_W-1:0]   LAST_CPOS  = CP_W'(SCREEN_WIDTH);
    localparam logic [7:0]        LAST_COL_B = 8'(SCREEN_WIDTH - 1);
    localparam logic [7:0]        LAST_PG_B  = 8'(PAGES - 1);

    // ------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_clr_addr;

    // write request being walked column by column
    logic signed [10:0] r_col;      // current column, may be off screen
    logic [PAGE_W-1:0]  r_page;
    logic [2:0]         r_bit;
    logic               r_y_ok;
    logic [7:0]         r_bits;     // pixel values, bit 0 is the current column
    logic [CNT_W-1:0]   r_cnt;      // columns still to read

    // pending write-back of the column read in the previous cycle
    logic               r_wp_valid;
    logic               r_wp_on;
    logic               r_wp_val;
    logic [ADDR_W-1:0]  r_wp_addr;
    logic [2:0]         r_wp_bit;

    // refresh stream position
    logic               r_in_cmd;
    logic [2:0]         r_cmd_pos;
    logic [PAGE_W-1:0]  r_str_page;
    logic [CP_W-1:0]    r_col_pos;  // 0 is the page prefix, c + 1 is column c

    // result register
    logic               r_o_valid;
    logic [7:0]         r_o_byte;
    logic               r_o_start;
    logic               r_o_last;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic               in_acc;
    t_req               req;
    logic               slot_free;
    logic               out_load;
    logic               col_ok;
    logic [ADDR_W-1:0]  glyph_addr;
    logic [ADDR_W-1:0]  str_addr;
    logic               str_need_rd;
    logic               y_ok_in;
    logic [7:0]         wb_mask;
    logic [7:0]         emit_byte;
    logic               emit_start;
    logic               emit_last;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [7:0]         ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [7:0]         ram_rd_data;

    assign req       = t_req'(i_req_type);
    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_o_valid || i_out_ready;

    assign y_ok_in = !i_pos_y[9] && (i_pos_y[8:0] < 9'(SCREEN_HEIGHT));
    assign col_ok  = !r_col[10] && (r_col[9:0] < 10'(SCREEN_WIDTH));

    assign glyph_addr = ADDR_W'(r_page) * WIDTH_A + ADDR_W'(r_col[COL_W-1:0]);
    assign str_addr   = ADDR_W'(r_str_page) * WIDTH_A + ADDR_W'(r_col_pos) - ADDR_W'(1);
    assign str_need_rd = !r_in_cmd && (r_col_pos != '0);

    assign wb_mask = 8'(1) << r_wp_bit;

    // refresh byte from the current stream position
    always_comb begin
        if (r_in_cmd) begin
            emit_byte = f_cmd_byte(r_cmd_pos, LAST_COL_B, LAST_PG_B);
        end else if (r_col_pos == '0) begin
            emit_byte = PAGE_PREFIX;
        end else begin
            emit_byte = ram_rd_data;
        end
    end

    assign emit_start = r_in_cmd ? (r_cmd_pos == CMD_POS_FIRST) : (r_col_pos == '0);
    assign emit_last  = !r_in_cmd && (r_str_page == LAST_PAGE) && (r_col_pos == LAST_CPOS);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_PIXEL, REQ_GLYPH: n_state = ST_RUN;
                        REQ_REFRESH:          n_state = ST_EMIT;
                        REQ_NONE:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: RAM ports, ready, result load
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = 1'b0;
        out_load    = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = glyph_addr;
        // write back the column read in the previous cycle
        ram_wr_en   = r_wp_valid && r_wp_on;
        ram_wr_addr = r_wp_addr;
        ram_wr_data = r_wp_val ? (ram_rd_data | wb_mask) : (ram_rd_data & ~wb_mask);
        unique case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                ram_rd_addr = str_addr;
                ram_rd_en   = in_acc && (req == REQ_REFRESH) && str_need_rd;
            end
            ST_RUN: begin
                ram_rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_EMIT: begin
                out_load = slot_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_wp_valid <= 1'b0;
            r_in_cmd   <= 1'b1;
            r_cmd_pos  <= CMD_POS_FIRST;
            r_str_page <= '0;
            r_col_pos  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end

            r_wp_valid <= (r_state == ST_RUN);

            // drop the result once taken, load a new one when the slot is free
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            // advance the stream position on every emitted byte
            if (out_load) begin
                if (r_in_cmd) begin
                    if (r_cmd_pos == CMD_POS_LAST) begin
                        r_in_cmd   <= 1'b0;
                        r_str_page <= '0;
                        r_col_pos  <= '0;
                    end else begin
                        r_cmd_pos <= r_cmd_pos + 3'd1;
                    end
                end else if (r_col_pos == LAST_CPOS) begin
                    r_col_pos <= '0;
                    if (r_str_page == LAST_PAGE) begin
                        r_in_cmd  <= 1'b1;
                        r_cmd_pos <= CMD_POS_FIRST;
                    end else begin
                        r_str_page <= r_str_page + PAGE_W'(1);
                    end
                end else begin
                    r_col_pos <= r_col_pos + CP_W'(1);
                end
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col  <= {i_pos_x[9], i_pos_x};
            r_page <= i_pos_y[3 +: PAGE_W];
            r_bit  <= i_pos_y[2:0];
            r_y_ok <= y_ok_in;
            if (req == REQ_PIXEL) begin
                r_bits <= {7'd0, i_color};
                r_cnt  <= CNT_W'(1);
            end else begin
                r_bits <= i_row_bits;
                r_cnt  <= CNT_W'(GLYPH_SPAN);
            end
        end else if (r_state == ST_RUN) begin
            // advance one column; glyph pixels past bit seven clear
            r_col  <= r_col + 11'sd1;
            r_bits <= {1'b0, r_bits[7:1]};
            r_cnt  <= r_cnt - CNT_W'(1);
        end

        if (r_state == ST_RUN) begin
            r_wp_on   <= r_y_ok && col_ok;
            r_wp_val  <= r_bits[0];
            r_wp_addr <= glyph_addr;
            r_wp_bit  <= r_bit;
        end

        if (out_load) begin
            r_o_byte  <= emit_byte;
            r_o_start <= emit_start;
            r_o_last  <= emit_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_out_byte       = r_o_byte;
    assign o_transfer_start = r_o_start;
    assign o_frame_last     = r_o_last;

    // ------------------------------------------------------------------
    // Pixel store
    // ------------------------------------------------------------------
    pfgw_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("pixel RAM read and write hit the same byte");

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_o_valid || i_out_ready))
        else $error("refresh byte overwrote an untaken result");

    a_last_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> !o_transfer_start)
        else $error("final frame byte flagged as transfer start");

    a_wb_follows_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && (r_state != ST_CLEAR)) |-> $past(r_state == ST_RUN))
        else $error("write-back without a preceding column read");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !(r_wp_valid || r_o_valid))
        else $error("activity during clearing pass");

endmodule

`default_nettype wire

>>> tb/sv/tb_page_framebuffer_glyph_writer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the page framebuffer glyph writer: directed table, then random mix.
module tb_page_framebuffer_glyph_writer;
    import pfgw_pkg::*;

    // Screen geometry at the block's default sizes
    localparam int SCR_W     = SCREEN_WIDTH_DEF;
    localparam int SCR_H     = SCREEN_HEIGHT_DEF;
    localparam int SPAN      = GLYPH_SPAN_DEF;
    localparam int N_PAGES   = (SCR_H + 7) / 8;
    localparam int PAGE_LEN  = SCR_W + 1;                  // prefix plus column bytes
    localparam int FRAME_LEN = CMD_COUNT + N_PAGES * PAGE_LEN;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 5;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int DRAIN_CYCLES    = 40;
    // clearing pass plus ~1.9k items at the slowest idle/stall mix, taken
    // several times over
    localparam int TIMEOUT_NS      = 3_000_000;
    localparam int MAX_REPORTS     = 40;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       last;
    } t_refresh_byte;

    // One request item, with an optional hand-typed refresh byte
    typedef struct {
        t_req                rq;
        logic signed [9:0]   x;
        logic signed [9:0]   y;
        logic                color;
        logic [7:0]          bits;
        bit                  has_typed;
        t_refresh_byte       typed_val;
    } t_req_item;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [1:0]        in_req   = REQ_PIXEL;
    logic signed [9:0] in_x     = '0;
    logic signed [9:0] in_y     = '0;
    logic              in_color = 1'b0;
    logic [7:0]        in_bits  = '0;
    logic              out_ready = 1'b0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [7:0]        o_out_byte;
    logic              o_transfer_start;
    logic              o_frame_last;

    // Hand-typed expectation travels with the item being driven
    bit                drv_has_typed = 1'b0;
    t_refresh_byte     drv_typed;

    // Predictor state: shadow pixel store and refresh stream position
    logic [7:0]        fb_mem [N_PAGES * SCR_W];
    int                frame_pos;
    t_refresh_byte     refresh_q [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int err_count = 0;
    int n_pixel   = 0;
    int n_glyph   = 0;
    int n_refresh = 0;
    int n_unused  = 0;
    int n_frames  = 0;

    t_req_item dir_rows [$];

    page_framebuffer_glyph_writer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (in_req),
        .i_pos_x          (in_x),
        .i_pos_y          (in_y),
        .i_color          (in_color),
        .i_row_bits       (in_bits),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_out_byte       (o_out_byte),
        .o_transfer_start (o_transfer_start),
        .o_frame_last     (o_frame_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Set or clear one pixel in the shadow store; drop anything off the screen
    task automatic fb_put(input int x, input int y, input logic c);
        int idx;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) begin
            return;
        end
        idx = (y / 8) * SCR_W + x;
        fb_mem[idx][y % 8] = c;
    endtask

    // Apply one accepted request to the shadow state; refresh requests yield a byte
    task automatic fb_step(
        input  logic [1:0]    rq,
        input  int            x,
        input  int            y,
        input  logic          c,
        input  logic [7:0]    bits,
        output bit            produced,
        output t_refresh_byte r
    );
        int q;
        produced = 1'b0;
        r.data   = '0;
        r.start  = 1'b0;
        r.last   = 1'b0;
        case (t_req'(rq))
            REQ_PIXEL: begin
                fb_put(x, y, c);
            end
            REQ_GLYPH: begin
                // pixels past bit seven are always cleared
                for (int k = 0; k < SPAN; k++) begin
                    fb_put(x + k, y, (k < 8) ? bits[k % 8] : 1'b0);
                end
            end
            REQ_REFRESH: begin
                produced = 1'b1;
                if (frame_pos < CMD_COUNT) begin
                    // address window: column range, then page range
                    case (frame_pos[2:0])
                        CMD_POS_COL:   r.data = CMD_COL_ADDR;
                        CMD_POS_COLE:  r.data = 8'(SCR_W - 1);
                        CMD_POS_PAGE:  r.data = CMD_PAGE_ADDR;
                        CMD_POS_PAGEE: r.data = 8'(N_PAGES - 1);
                        default:       r.data = CMD_LEAD;
                    endcase
                    r.start = (frame_pos == 0);
                end else begin
                    q = frame_pos - CMD_COUNT;
                    if (q % PAGE_LEN == 0) begin
                        r.data  = PAGE_PREFIX;
                        r.start = 1'b1;
                    end else begin
                        // column bytes are read at the moment they are emitted
                        r.data = fb_mem[(q / PAGE_LEN) * SCR_W + q % PAGE_LEN - 1];
                    end
                end
                r.last    = (frame_pos == FRAME_LEN - 1);
                frame_pos = r.last ? 0 : frame_pos + 1;
            end
            default: begin
                // unused code: no state change, no byte
            end
        endcase
    endtask

    function automatic void add_dir(
        input t_req       rq,
        input int         x,
        input int         y,
        input logic       c,
        input logic [7:0] bits,
        input bit         has_typed,
        input logic [7:0] data,
        input logic       start,
        input logic       last
    );
        t_req_item row;
        row.rq              = rq;
        row.x               = 10'(x);
        row.y               = 10'(y);
        row.color           = c;
        row.bits            = bits;
        row.has_typed       = has_typed;
        row.typed_val.data  = data;
        row.typed_val.start = start;
        row.typed_val.last  = last;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void note_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, what, want, got);
        end
    endfunction

    // Drive one item at the falling edge, idle first at random, hold until accepted
    task automatic send_item(input t_req_item row);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid      <= 1'b1;
        in_req        <= row.rq;
        in_x          <= row.x;
        in_y          <= row.y;
        in_color      <= row.color;
        in_bits       <= row.bits;
        drv_has_typed <= row.has_typed;
        drv_typed     <= row.typed_val;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: stall the refresh byte channel at the phase's rate
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sample both channels at the rising edge: check results first, then predict
    always @(posedge i_clk) begin : monitor
        t_refresh_byte want;
        t_refresh_byte pred;
        bit            produced;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && out_ready) begin
                if (refresh_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t ns: refresh byte %02h with nothing expected",
                                 $time, o_out_byte);
                    end
                end else begin
                    want = refresh_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        note_mismatch("out_byte", want.data, o_out_byte);
                    end
                    if (o_transfer_start !== want.start) begin
                        note_mismatch("transfer_start", 8'(want.start), 8'(o_transfer_start));
                    end
                    if (o_frame_last !== want.last) begin
                        note_mismatch("frame_last", 8'(want.last), 8'(o_frame_last));
                    end
                    if (want.last) begin
                        n_frames++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                case (t_req'(in_req))
                    REQ_PIXEL:   n_pixel++;
                    REQ_GLYPH:   n_glyph++;
                    REQ_REFRESH: n_refresh++;
                    default:     n_unused++;
                endcase
                fb_step(in_req, int'(in_x), int'(in_y), in_color, in_bits, produced, pred);
                if (produced) begin
                    want      = drv_has_typed ? drv_typed : pred;
                    refresh_q = {refresh_q, want};
                end
            end
        end
    end

    initial begin : stimulus
        t_req_item row;
        int        sel;
        foreach (fb_mem[i]) begin
            fb_mem[i] = '0;
        end
        frame_pos = 0;

        // Directed table. The first frame bytes after reset are typed in; the rest
        // go through the predictor.
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, CMD_LEAD,          1, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, CMD_COL_ADDR,      0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, CMD_LEAD,          0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, 8'(SCR_W - 1),     0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, CMD_PAGE_ADDR,     0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, CMD_LEAD,          0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, 8'(N_PAGES - 1),   0, 0);
        add_dir(REQ_REFRESH, 0, 0, 0, 8'h00, 1, PAGE_PREFIX,       1, 0);
        // corner pixels, then pixels off every edge, some just off and some at the field extremes
        add_dir(REQ_PIXEL,   0,         0,         1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   SCR_W - 1, SCR_H - 1, 1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   -512,      5,         1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   511,       -1,        1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   SCR_W,     0,         1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   3,         SCR_H,     1, 8'h00, 0, '0, 0, 0);
        // glyph rows clipped at the left and right edges
        add_dir(REQ_GLYPH,   -3,        0,         0, 8'hFF, 0, '0, 0, 0);
        add_dir(REQ_GLYPH,   SCR_W - 5, 7,         0, 8'hA5, 0, '0, 0, 0);
        // second row overlaps the first: its cleared ninth pixel lands on column 8
        add_dir(REQ_GLYPH,   8,         2,         0, 8'hFF, 0, '0, 0, 0);
        add_dir(REQ_GLYPH,   0,         2,         0, 8'hFF, 0, '0, 0, 0);
        add_dir(REQ_GLYPH,   -512,      511,       1, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_PIXEL,   1,         0,         0, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_NONE,    -1,        -1,        1, 8'hFF, 0, '0, 0, 0);
        add_dir(REQ_REFRESH, 511,       -512,      1, 8'hFF, 0, '0, 0, 0);
        add_dir(REQ_REFRESH, 0,         0,         0, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_REFRESH, 0,         0,         0, 8'h00, 0, '0, 0, 0);
        add_dir(REQ_REFRESH, 0,         0,         0, 8'h00, 0, '0, 0, 0);

        // Hold reset, then release at a falling edge; the clearing pass shows up as
        // a long stretch of o_in_ready low
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i]);
        end

        // Random part in four idling phases
        row.has_typed = 1'b0;
        row.typed_val = '{data: '0, start: 1'b0, last: 1'b0};
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 87; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // start from full-range noise so every field bit toggles
                row.x     = 10'($urandom);
                row.y     = 10'($urandom);
                row.color = 1'($urandom);
                row.bits  = 8'($urandom);
                sel       = $urandom_range(99);
                if (sel < 64) begin
                    // enough refresh bytes to stream more than a whole frame
                    row.rq = REQ_REFRESH;
                end else if (sel < 81) begin
                    row.rq = REQ_GLYPH;
                    if ($urandom_range(4) != 0) begin
                        row.x = 10'(int'($urandom_range(SCR_W + SPAN + 2)) - SPAN - 1);
                        row.y = 10'(int'($urandom_range(SCR_H + 3)) - 2);
                    end
                end else if (sel < 97) begin
                    row.rq = REQ_PIXEL;
                    if ($urandom_range(4) != 0) begin
                        row.x = 10'(int'($urandom_range(SCR_W + 3)) - 2);
                        row.y = 10'(int'($urandom_range(SCR_H + 3)) - 2);
                    end
                end else begin
                    row.rq = REQ_NONE;
                end
                send_item(row);
            end
        end

        // Drop valid, let the receiver run freely and drain the expectations
        @(negedge i_clk);
        in_valid  <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (refresh_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d pixel writes, %0d glyph rows, %0d refresh bytes, %0d unused codes",
                 n_pixel, n_glyph, n_refresh, n_unused);
        $display("%0d full frames streamed under four idle/stall mixes, %0d mismatches",
                 n_frames, err_count);
        if (err_count == 0 && refresh_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: end the run if the handshakes ever hang
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout at %0t ns with %0d refresh bytes outstanding", $time, refresh_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
